// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the command decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define SCD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition in one cycle implies a condition in the next cycle
`define SCD_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== src/scd_pkg.sv =====
// ----------------------------------------------------------------------------
// SUMP command decoder package
// Event kinds, opcodes, queue entry type and ID string shared by all modules.
// ----------------------------------------------------------------------------
package scd_pkg;

   // default depth of the command queue between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // decoded event kinds
   typedef enum logic [3:0] {
      EV_ID         = 4'd0,
      EV_RUN        = 4'd1,
      EV_RESET      = 4'd2,
      EV_XON        = 4'd3,
      EV_XOFF       = 4'd4,
      EV_MASK       = 4'd5,
      EV_VALUE      = 4'd6,
      EV_TRIG_CFG   = 4'd7,
      EV_DIVIDER    = 4'd8,
      EV_READ_DELAY = 4'd9,
      EV_FLAGS      = 4'd10,
      EV_UNKNOWN    = 4'd11
   } event_kind_type;

   // short opcodes
   localparam logic [7:0] OP_RESET = 8'h00;
   localparam logic [7:0] OP_RUN   = 8'h01;
   localparam logic [7:0] OP_ID    = 8'h02;
   localparam logic [7:0] OP_XON   = 8'h11;
   localparam logic [7:0] OP_XOFF  = 8'h13;

   // long opcodes
   localparam logic [7:0] OP_DIVIDER    = 8'h80;
   localparam logic [7:0] OP_READ_DELAY = 8'h81;
   localparam logic [7:0] OP_FLAGS      = 8'h82;
   localparam logic [3:0] OP_STAGE_GRP  = 4'hC;

   // low two opcode bits within the stage group
   localparam logic [1:0] STG_MASK  = 2'd0;
   localparam logic [1:0] STG_VALUE = 2'd1;
   localparam logic [1:0] STG_CFG   = 2'd2;

   // data bytes per long command
   localparam logic [2:0] POS_IDLE = 3'd0;
   localparam logic [2:0] POS_LAST = 3'd4;

   // one decoded command waiting for the back end
   typedef struct packed {
      event_kind_type kind;
      logic [1:0]     stage;
      logic [31:0]    word;
   } cmd_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic not_full;
      logic not_empty;
   } q_status_type;

   // ID string "1ALS", sent first to last
   function automatic logic [7:0] id_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h31;
         2'd1:    b = 8'h41;
         2'd2:    b = 8'h4C;
         default: b = 8'h53;
      endcase
      return b;
   endfunction

   // opcodes that collect four data bytes
   function automatic logic is_long_op(input logic [7:0] op);
      return (op == OP_DIVIDER) || (op == OP_READ_DELAY) || (op == OP_FLAGS) ||
             ((op[7:4] == OP_STAGE_GRP) && (op[1:0] != 2'd3));
   endfunction

endpackage

// ===== src/scd_front.sv =====
// ----------------------------------------------------------------------------
// Command decoder front end
// Takes command bytes, gathers data bytes and queues one entry per command.
// ----------------------------------------------------------------------------
module scd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  scd_pkg::q_status_type q_status,
   output logic                 push,
   output scd_pkg::cmd_type     push_cmd
);
   import scd_pkg::*;

   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [23:0] gather_ff, gather_in;
   logic        accept;
   cmd_type     short_cmd, long_cmd;

   assign req_ready = q_status.not_full;
   assign accept    = req_valid && req_ready;

   // short opcode classification
   always_comb begin
      short_cmd = '{kind: EV_UNKNOWN, stage: 2'd0, word: 32'd0};
      unique case (req_rx_byte)
         OP_RESET: short_cmd.kind = EV_RESET;
         OP_RUN:   short_cmd.kind = EV_RUN;
         OP_ID:    short_cmd.kind = EV_ID;
         OP_XON:   short_cmd.kind = EV_XON;
         OP_XOFF:  short_cmd.kind = EV_XOFF;
         default:  short_cmd.kind = EV_UNKNOWN;
      endcase
   end

   // long command classification on the final data byte
   always_comb begin
      long_cmd = '{kind: EV_FLAGS, stage: 2'd0, word: {req_rx_byte, gather_ff}};
      if (opcode_ff[7:4] == OP_STAGE_GRP) begin
         long_cmd.stage = opcode_ff[3:2];
         case (opcode_ff[1:0])
            STG_MASK:  long_cmd.kind = EV_MASK;
            STG_VALUE: long_cmd.kind = EV_VALUE;
            default:   long_cmd.kind = EV_TRIG_CFG;
         endcase
      end else if (opcode_ff == OP_DIVIDER) begin
         long_cmd.kind = EV_DIVIDER;
      end else if (opcode_ff == OP_READ_DELAY) begin
         long_cmd.kind = EV_READ_DELAY;
      end
   end

   // byte position tracking and queue push
   always_comb begin
      pos_in    = pos_ff;
      opcode_in = opcode_ff;
      gather_in = gather_ff;
      push      = 1'b0;
      push_cmd  = short_cmd;
      if (accept) begin
         if (pos_ff == POS_IDLE) begin
            if (is_long_op(req_rx_byte)) begin
               opcode_in = req_rx_byte;
               gather_in = 24'd0;
               pos_in    = 3'd1;
            end else begin
               push = 1'b1;
            end
         end else if (pos_ff < POS_LAST) begin
            case (pos_ff[1:0])
               2'd1:    gather_in = gather_ff | {16'd0, req_rx_byte};
               2'd2:    gather_in = gather_ff | {8'd0, req_rx_byte, 8'd0};
               default: gather_in = gather_ff | {req_rx_byte, 16'd0};
            endcase
            pos_in = pos_ff + 3'd1;
         end else begin
            push      = 1'b1;
            push_cmd  = long_cmd;
            pos_in    = POS_IDLE;
            gather_in = 24'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_IDLE;
         opcode_ff <= 8'd0;
         gather_ff <= 24'd0;
      end else begin
         pos_ff    <= pos_in;
         opcode_ff <= opcode_in;
         gather_ff <= gather_in;
      end
   end

endmodule

// ===== src/scd_queue.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Small FIFO of decoded commands between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scd_queue #(
   parameter int DEPTH = scd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  scd_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output scd_pkg::cmd_type      head,
   output scd_pkg::q_status_type status
);
   import scd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.not_full  = (count_ff != CNT_W'(DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign head             = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `SCD_ASSERT(a_q_no_overflow, push |-> status.not_full, "command queue overflow")
   `SCD_ASSERT(a_q_no_underflow, pop |-> status.not_empty, "command queue underflow")

endmodule

// ===== src/scd_back.sv =====
// ----------------------------------------------------------------------------
// Command decoder back end
// Expands queued commands into result words and holds them in an output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  scd_pkg::cmd_type      head,
   input  scd_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_event_kind,
   output logic [1:0]            rsp_stage_index,
   output logic [31:0]           rsp_data_word,
   output logic [7:0]            rsp_trig_delay,
   output logic [4:0]            rsp_trig_channel,
   output logic [1:0]            rsp_trig_level,
   output logic                  rsp_trig_serial,
   output logic                  rsp_trig_start,
   output logic [24:0]           rsp_clock_divider,
   output logic [15:0]           rsp_read_samples,
   output logic [15:0]           rsp_delay_samples,
   output logic                  rsp_last_of_run
);
   import scd_pkg::*;

   logic        valid_ff, valid_in;
   logic [1:0]  id_cnt_ff, id_cnt_in;
   logic        load, is_id, last;
   logic [31:0] rev;

   logic [3:0]  kind_ff, kind_in;
   logic [1:0]  stage_ff, stage_in;
   logic [31:0] data_ff, data_in;
   logic [7:0]  tdelay_ff, tdelay_in;
   logic [4:0]  tchan_ff, tchan_in;
   logic [1:0]  tlevel_ff, tlevel_in;
   logic        tserial_ff, tserial_in;
   logic        tstart_ff, tstart_in;
   logic [24:0] div_ff, div_in;
   logic [15:0] rdcnt_ff, rdcnt_in;
   logic [15:0] dlcnt_ff, dlcnt_in;
   logic        last_ff, last_in;

   // output stage loads when empty or being drained
   assign is_id = (head.kind == EV_ID);
   assign last  = !is_id || (id_cnt_ff == 2'd3);
   assign load  = q_status.not_empty && (!valid_ff || rsp_ready);
   assign pop   = load && last;

   // full 32-bit reversal of the command word
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         rev[i] = head.word[31-i];
      end
   end

   // result fields for the head command
   always_comb begin
      kind_in    = head.kind;
      stage_in   = 2'd0;
      data_in    = 32'd0;
      tdelay_in  = 8'd0;
      tchan_in   = 5'd0;
      tlevel_in  = 2'd0;
      tserial_in = 1'b0;
      tstart_in  = 1'b0;
      div_in     = 25'd0;
      rdcnt_in   = 16'd0;
      dlcnt_in   = 16'd0;
      last_in    = last;
      unique case (head.kind)
         EV_ID: begin
            data_in = {24'd0, id_byte(id_cnt_ff)};
         end
         EV_MASK, EV_VALUE: begin
            stage_in = head.stage;
            data_in  = head.word;
         end
         EV_TRIG_CFG: begin
            stage_in   = head.stage;
            tdelay_in  = rev[31:24] | rev[23:16];
            tchan_in   = {rev[0], rev[15:12]};
            tlevel_in  = rev[5:4];
            tserial_in = rev[2];
            tstart_in  = rev[3];
         end
         EV_DIVIDER: begin
            div_in = {1'b0, head.word[23:0]} + 25'd1;
         end
         EV_READ_DELAY: begin
            rdcnt_in = head.word[15:0];
            dlcnt_in = head.word[31:16];
         end
         EV_FLAGS: begin
            data_in = {24'd0, head.word[7:0]};
         end
         default: begin
            data_in = 32'd0;
         end
      endcase
   end

   // control: output valid and id byte counter
   always_comb begin
      valid_in  = valid_ff;
      id_cnt_in = id_cnt_ff;
      if (load) begin
         valid_in = 1'b1;
         if (is_id) begin
            id_cnt_in = id_cnt_ff + 2'd1;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         id_cnt_ff <= 2'd0;
      end else begin
         valid_ff  <= valid_in;
         id_cnt_ff <= id_cnt_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= kind_in;
         stage_ff   <= stage_in;
         data_ff    <= data_in;
         tdelay_ff  <= tdelay_in;
         tchan_ff   <= tchan_in;
         tlevel_ff  <= tlevel_in;
         tserial_ff <= tserial_in;
         tstart_ff  <= tstart_in;
         div_ff     <= div_in;
         rdcnt_ff   <= rdcnt_in;
         dlcnt_ff   <= dlcnt_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_stage_index   = stage_ff;
   assign rsp_data_word     = data_ff;
   assign rsp_trig_delay    = tdelay_ff;
   assign rsp_trig_channel  = tchan_ff;
   assign rsp_trig_level    = tlevel_ff;
   assign rsp_trig_serial   = tserial_ff;
   assign rsp_trig_start    = tstart_ff;
   assign rsp_clock_divider = div_ff;
   assign rsp_read_samples  = rdcnt_ff;
   assign rsp_delay_samples = dlcnt_ff;
   assign rsp_last_of_run   = last_ff;

   `SCD_ASSERT(a_bk_not_last_is_id, (valid_ff && !last_ff) |-> (kind_ff == EV_ID),
      "non-final word on a command other than id")
   `SCD_ASSERT_NEXT(a_bk_id_holds, load && is_id && !last,
      q_status.not_empty && (head.kind == EV_ID), "id command left queue early")
   `SCD_ASSERT(a_bk_cnt_idle, (id_cnt_ff != 2'd0) |-> (q_status.not_empty && is_id),
      "id counter running without an id command")

endmodule

// ===== src/sump_command_decoder.sv =====
// ----------------------------------------------------------------------------
// SUMP command decoder
// Turns SUMP command bytes into decoded command events.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one command byte per word (req_rx_byte), opcode first,
//   then four data bytes least significant first for long commands.
//   rsp_ channel: one decoded event per word; id gives four words,
//   rsp_last_of_run marks the final word caused by one input byte.
// Timing:
//   The first result of a completing byte passes through the command queue
//   and the output stage register before it shows on the rsp_ ports.
//   One byte is taken per cycle while the command queue has room;
//   each queued command leaves one result per cycle while rsp_ready is high;
//   id gives four results, set by the result counter in the back end.
// Stall:
//   When rsp_ready is low the output word holds and the queue fills; once it
//   is full req_ready drops until the back end drains an entry.
// Reset:
//   Synchronous, active high. Clears the byte position, the queue and the
//   output stage; the decoder then waits for an opcode.
// ----------------------------------------------------------------------------
module sump_command_decoder #(
   parameter int QUEUE_DEPTH = scd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_event_kind,
   output logic [1:0]  rsp_stage_index,
   output logic [31:0] rsp_data_word,
   output logic [7:0]  rsp_trig_delay,
   output logic [4:0]  rsp_trig_channel,
   output logic [1:0]  rsp_trig_level,
   output logic        rsp_trig_serial,
   output logic        rsp_trig_start,
   output logic [24:0] rsp_clock_divider,
   output logic [15:0] rsp_read_samples,
   output logic [15:0] rsp_delay_samples,
   output logic        rsp_last_of_run
);
   import scd_pkg::*;

   q_status_type q_status;
   logic         push, pop;
   cmd_type      push_cmd, head;

   // byte gathering and classification
   scd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // decoded command queue
   scd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // result expansion and output stage
   scd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_status          (q_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_stage_index   (rsp_stage_index),
      .rsp_data_word     (rsp_data_word),
      .rsp_trig_delay    (rsp_trig_delay),
      .rsp_trig_channel  (rsp_trig_channel),
      .rsp_trig_level    (rsp_trig_level),
      .rsp_trig_serial   (rsp_trig_serial),
      .rsp_trig_start    (rsp_trig_start),
      .rsp_clock_divider (rsp_clock_divider),
      .rsp_read_samples  (rsp_read_samples),
      .rsp_delay_samples (rsp_delay_samples),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SUMP command decoder testbench
// Feeds command bytes to the decoder, opcodes and data bytes mixed with noise,
// and checks every decoded event word against an in-bench decoder model,
// with random idle cycles on both channels and pauses until drained.
// ----------------------------------------------------------------------------
module testbench;
   import scd_pkg::*;

   localparam int NUM_RANDOM  = 470;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 12;

   // one pending command byte; hold makes the sender wait for a drained decoder
   typedef struct {
      logic [7:0] rx;
      bit         hold;
   } pending_byte_type;

   // one expected decoded event
   typedef struct {
      event_kind_type kind;
      logic [1:0]     stage;
      logic [31:0]    data;
      logic [7:0]     delay;
      logic [4:0]     channel;
      logic [1:0]     level;
      logic           serial;
      logic           start;
      logic [24:0]    divider;
      logic [15:0]    rd_count;
      logic [15:0]    dl_count;
      logic           last;
   } decoded_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_event_kind;
   logic [1:0]  rsp_stage_index;
   logic [31:0] rsp_data_word;
   logic [7:0]  rsp_trig_delay;
   logic [4:0]  rsp_trig_channel;
   logic [1:0]  rsp_trig_level;
   logic        rsp_trig_serial;
   logic        rsp_trig_start;
   logic [24:0] rsp_clock_divider;
   logic [15:0] rsp_read_samples;
   logic [15:0] rsp_delay_samples;
   logic        rsp_last_of_run;

   pending_byte_type  pending_bytes[$];
   decoded_event_type expected_events[$];

   // decoder model state
   logic [2:0]  byte_pos   = POS_IDLE;
   logic [7:0]  cmd_opcode = 8'h00;
   logic [23:0] cmd_bytes  = 24'h0;

   int unsigned words_in       = 0;
   int unsigned words_out      = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   bit          kinds_seen[12];
   logic        calm;

   sump_command_decoder u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_stage_index   (rsp_stage_index),
      .rsp_data_word     (rsp_data_word),
      .rsp_trig_delay    (rsp_trig_delay),
      .rsp_trig_channel  (rsp_trig_channel),
      .rsp_trig_level    (rsp_trig_level),
      .rsp_trig_serial   (rsp_trig_serial),
      .rsp_trig_start    (rsp_trig_start),
      .rsp_clock_divider (rsp_clock_divider),
      .rsp_read_samples  (rsp_read_samples),
      .rsp_delay_samples (rsp_delay_samples),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // no idling on either side over a stretch of the run
   assign calm = (words_in >= 200) && (words_in < 320);

   // error reporting
   task automatic flag_error(input string msg);
      mismatch_count++;
      $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_error($sformatf("word %0d %s: got 0x%0h, expected 0x%0h",
                              words_out, name, got, want));
   endtask

   function automatic decoded_event_type blank_event(input event_kind_type kind);
      decoded_event_type ev;
      ev = '{kind: kind, stage: 2'd0, data: 32'h0, delay: 8'h0, channel: 5'h0,
             level: 2'd0, serial: 1'b0, start: 1'b0, divider: 25'h0,
             rd_count: 16'h0, dl_count: 16'h0, last: 1'b1};
      return ev;
   endfunction

   function automatic bit opcode_is_long(input logic [7:0] op);
      return (op == OP_DIVIDER) || (op == OP_READ_DELAY) || (op == OP_FLAGS) ||
             ((op[7:4] == OP_STAGE_GRP) && (op[1:0] != 2'b11));
   endfunction

   // decode a finished long command into one event
   function automatic decoded_event_type decode_command(input logic [7:0] op,
                                                        input logic [31:0] w);
      decoded_event_type ev;
      logic [31:0]       r;
      for (int i = 0; i < 32; i++)
         r[31 - i] = w[i];
      if (op[7:4] == OP_STAGE_GRP) begin
         case (op[1:0])
            STG_MASK:  ev = blank_event(EV_MASK);
            STG_VALUE: ev = blank_event(EV_VALUE);
            default:   ev = blank_event(EV_TRIG_CFG);
         endcase
         ev.stage = op[3:2];
         if (op[1:0] == STG_CFG) begin
            ev.delay   = r[31:24] | r[23:16];
            ev.channel = {r[0], r[15:12]};
            ev.level   = r[5:4];
            ev.serial  = r[2];
            ev.start   = r[3];
         end else begin
            ev.data = w;
         end
      end else if (op == OP_DIVIDER) begin
         ev = blank_event(EV_DIVIDER);
         ev.divider = {1'b0, w[23:0]} + 25'd1;
      end else if (op == OP_READ_DELAY) begin
         ev = blank_event(EV_READ_DELAY);
         ev.rd_count = w[15:0];
         ev.dl_count = w[31:16];
      end else begin
         ev = blank_event(EV_FLAGS);
         ev.data = {24'h0, w[7:0]};
      end
      return ev;
   endfunction

   // advance the decoder model by one accepted byte, queue the events it gives
   task automatic predict_events(input logic [7:0] b);
      decoded_event_type ev;
      logic [7:0]        id_str[4];
      id_str = '{8'h31, 8'h41, 8'h4C, 8'h53};
      if (byte_pos == POS_IDLE) begin
         if (opcode_is_long(b)) begin
            cmd_opcode = b;
            cmd_bytes  = 24'h0;
            byte_pos   = 3'd1;
         end else if (b == OP_ID) begin
            for (int k = 0; k < 4; k++) begin
               ev = blank_event(EV_ID);
               ev.data = {24'h0, id_str[k]};
               ev.last = (k == 3);
               expected_events.push_back(ev);
            end
         end else begin
            case (b)
               OP_RESET: ev = blank_event(EV_RESET);
               OP_RUN:   ev = blank_event(EV_RUN);
               OP_XON:   ev = blank_event(EV_XON);
               OP_XOFF:  ev = blank_event(EV_XOFF);
               default:  ev = blank_event(EV_UNKNOWN);
            endcase
            expected_events.push_back(ev);
         end
      end else if (byte_pos < POS_LAST) begin
         cmd_bytes[(byte_pos - 3'd1) * 8 +: 8] = b;
         byte_pos = byte_pos + 3'd1;
      end else begin
         expected_events.push_back(decode_command(cmd_opcode, {b, cmd_bytes}));
         byte_pos  = POS_IDLE;
         cmd_bytes = 24'h0;
      end
   endtask

   // compare one accepted event word with the oldest expectation
   task automatic check_event();
      decoded_event_type ev;
      if (expected_events.size() == 0) begin
         flag_error($sformatf("unexpected event word, kind %0d", rsp_event_kind));
      end else begin
         ev = expected_events.pop_front();
         check_field("event_kind", rsp_event_kind, ev.kind);
         check_field("stage_index", rsp_stage_index, ev.stage);
         check_field("data_word", rsp_data_word, ev.data);
         check_field("trig_delay", rsp_trig_delay, ev.delay);
         check_field("trig_channel", rsp_trig_channel, ev.channel);
         check_field("trig_level", rsp_trig_level, ev.level);
         check_field("trig_serial", rsp_trig_serial, ev.serial);
         check_field("trig_start", rsp_trig_start, ev.start);
         check_field("clock_divider", rsp_clock_divider, ev.divider);
         check_field("read_samples", rsp_read_samples, ev.rd_count);
         check_field("delay_samples", rsp_delay_samples, ev.dl_count);
         check_field("last_of_run", rsp_last_of_run, ev.last);
         if (rsp_event_kind < 12)
            kinds_seen[rsp_event_kind] = 1'b1;
      end
      words_out++;
   endtask

   // stimulus helpers
   task automatic queue_byte(input logic [7:0] b, input bit hold = 1'b0);
      pending_byte_type p;
      p.rx   = b;
      p.hold = hold;
      pending_bytes.push_back(p);
   endtask

   function automatic logic [7:0] random_data_byte();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         return 8'h00;
      else if (pick < 30)
         return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_command(input logic [7:0] op, input bit hold = 1'b0);
      queue_byte(op, hold);
      if (opcode_is_long(op))
         for (int i = 0; i < 4; i++)
            queue_byte(random_data_byte());
   endtask

   task automatic queue_long(input logic [7:0] op, input logic [31:0] w);
      queue_byte(op);
      for (int i = 0; i < 4; i++)
         queue_byte(w[i * 8 +: 8]);
   endtask

   // pick one random command, mostly well formed
   function automatic logic [7:0] random_opcode();
      int unsigned   pick;
      logic [7:0]    short_ops[5];
      logic [7:0]    count_ops[3];
      short_ops = '{OP_RESET, OP_RUN, OP_ID, OP_XON, OP_XOFF};
      count_ops = '{OP_DIVIDER, OP_READ_DELAY, OP_FLAGS};
      pick = $urandom_range(0, 99);
      if (pick < 35)
         return {OP_STAGE_GRP, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 2))};
      else if (pick < 52)
         return count_ops[$urandom_range(0, 2)];
      else if (pick < 75)
         return short_ops[$urandom_range(0, 4)];
      else if (pick < 85)
         return {OP_STAGE_GRP, 2'($urandom_range(0, 3)), 2'b11};
      return 8'($urandom_range(0, 255));
   endfunction

   // sender: presents queued bytes, idles at random
   always @(posedge clock) begin : drive_req
      bit take;
      if (!reset && (!req_valid || req_ready)) begin
         take = (pending_bytes.size() != 0) && (calm || $urandom_range(0, 99) >= 26);
         // a held byte goes out only once the decoder has drained
         if (take && pending_bytes[0].hold &&
             (req_valid || expected_events.size() != 0 || rsp_valid))
            take = 1'b0;
         if (take) begin
            req_rx_byte <= pending_bytes[0].rx;
            req_valid   <= 1'b1;
            pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: checks event words, models accepted bytes, stalls at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_event();
         if (req_valid && req_ready) begin
            predict_events(req_rx_byte);
            words_in++;
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 26);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d events outstanding",
                  cycle_count, expected_events.size());
         $display("** sump_command_decoder: FAILED **");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      int unsigned kind_total;
      // directed: every short opcode, unknowns, extreme data words
      queue_byte(OP_RESET);
      queue_byte(OP_RUN);
      queue_byte(OP_ID);
      queue_byte(OP_XON);
      queue_byte(OP_XOFF);
      queue_byte(8'hFF);
      queue_long(OP_DIVIDER, 32'hFFFF_FFFF);
      queue_long({OP_STAGE_GRP, 2'd3, STG_CFG}, 32'hF00F_5AA5);
      queue_long(OP_READ_DELAY, 32'h0000_0000);
      queue_byte({OP_STAGE_GRP, 2'd3, 2'b11});
      queue_byte(OP_ID);

      // random commands, with drained pauses at random in two windows
      while (pending_bytes.size() < NUM_RANDOM)
         queue_command(random_opcode(),
                       (pending_bytes.size() inside {[120:124], [380:384]}) &&
                       $urandom_range(0, 3) == 0);
      queue_command(OP_RUN, 1'b1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      kind_total = 0;
      foreach (kinds_seen[k])
         kind_total += kinds_seen[k];
      $display("Sent %0d command bytes, checked %0d event words over %0d of 12 kinds.",
               words_in, words_out, kind_total);
      $display("Mismatches: %0d", mismatch_count);
      if (mismatch_count == 0 && expected_events.size() == 0)
         $display("** sump_command_decoder: PASSED **");
      else
         $display("** sump_command_decoder: FAILED **");
      $finish;
   end

endmodule
